[sv/acmac_pkg.sv]
// Shared types, constants and AES helper functions for the CMAC tag generator.
package acmac_pkg;

	localparam int unsigned KeyWidth   = 64;
	localparam int unsigned BlockWidth = 128;
	localparam int unsigned BlockBytes = 16;
	localparam int unsigned FillWidth  = 5;
	localparam int unsigned CfgIdxWidth = 1;
	localparam logic [7:0] CmacRb  = 8'h87;
	localparam logic [7:0] CmacPad = 8'h80;

	localparam logic [CfgIdxWidth-1:0] RegKeyHigh = 1'b0;
	localparam logic [CfgIdxWidth-1:0] RegKeyLow  = 1'b1;

	typedef enum logic [1:0] {
		SRC_ZERO,
		SRC_CHAIN,
		SRC_FINAL
	} aes_src_t;

	// controller to datapath
	typedef struct packed {
		logic     buf_write;
		logic     fill_clear;
		logic     aes_start;
		aes_src_t aes_src;
		logic     keep_subkeys;
		logic     keep_chain;
		logic     msg_clear;
		logic     tag_load;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic aes_done;
		logic buf_full;
	} dp_status_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[a];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	// byte i of a 128-bit block, byte 0 most significant
	function automatic logic [7:0] blk_byte(input logic [BlockWidth-1:0] b, input int i);
		return b[BlockWidth-1-8*i -: 8];
	endfunction

	function automatic logic [BlockWidth-1:0] next_round_key(
		input logic [BlockWidth-1:0] k, input logic [7:0] rc);
		logic [31:0] w [4];
		logic [31:0] t;
		logic [BlockWidth-1:0] r;
		for (int i = 0; i < 4; i++) w[i] = k[BlockWidth-1-32*i -: 32];
		t = {sbox(w[3][23:16]) ^ rc, sbox(w[3][15:8]), sbox(w[3][7:0]), sbox(w[3][31:24])};
		w[0] = w[0] ^ t;
		w[1] = w[1] ^ w[0];
		w[2] = w[2] ^ w[1];
		w[3] = w[3] ^ w[2];
		r = {w[0], w[1], w[2], w[3]};
		return r;
	endfunction

	function automatic logic [BlockWidth-1:0] aes_round(
		input logic [BlockWidth-1:0] s, input logic [BlockWidth-1:0] rk, input logic last);
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, al;
		logic [BlockWidth-1:0] r;
		for (int c = 0; c < 4; c++)
			for (int i = 0; i < 4; i++)
				t[i+4*c] = sbox(blk_byte(s, i + 4*((c+i) & 3)));
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
				al = a0 ^ a1 ^ a2 ^ a3;
				t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
				t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
				t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
				t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) r[BlockWidth-1-8*i -: 8] = t[i];
		return r ^ rk;
	endfunction

	function automatic logic [BlockWidth-1:0] dbl(input logic [BlockWidth-1:0] v);
		return {v[BlockWidth-2:0], 1'b0} ^ {{(BlockWidth-8){1'b0}}, (v[BlockWidth-1] ? CmacRb : 8'h00)};
	endfunction

endpackage

[sv/aes_cmac_tag_generator.sv]
// Top level of the AES-128 CMAC tag generator.
// Usage:
//   Write key_high (index 0) and key_low (index 1) over the cfg port while idle;
//   a write drops any message in progress and forces new subkeys.
//   Message bytes arrive on the input channel one beat each (has_byte marks a
//   byte, last_of_message ends the message). The tag leaves on the output
//   channel as tag_high/tag_low.
// Sequence:
//   After reset or a key write, subkey derivation runs before the first
//   beat is taken. A byte into a non-full buffer is written there directly.
//   A byte that follows a full block waits while the round-iterative AES
//   core (one round per cycle, 10 rounds) chains that block. The tag shows
//   once the final block is encrypted, after such a chain step if the final
//   beat follows a full block; the next beat can be taken in the cycle after
//   the tag leaves.
// Reset clears all control state; the subkeys are derived again.
// While the receiver stalls, the tag holds and no input beat is taken.
module aes_cmac_tag_generator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [0:0]                      cfg_idx,
	input  logic [acmac_pkg::KeyWidth-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      data_byte,
	input  logic                            has_byte,
	input  logic                            last_of_message,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [acmac_pkg::KeyWidth-1:0]  tag_high,
	output logic [acmac_pkg::KeyWidth-1:0]  tag_low
);
	acmac_pkg::dp_cmd_t    cmd;
	acmac_pkg::dp_status_t status;
	logic [acmac_pkg::BlockWidth-1:0] tag;

	acmac_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .in_valid(in_valid),
		.in_stall(in_stall), .has_byte(has_byte), .last_of_message(last_of_message),
		.out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
	);

	acmac_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .byte_in(data_byte), .cmd(cmd), .status(status), .tag(tag)
	);

	assign tag_high = tag[127:64];
	assign tag_low  = tag[63:0];
endmodule

[sv/acmac_aes_core.sv]
// Round-iterative AES-128 encryption core, one round per cycle, round keys on the fly.
module acmac_aes_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [acmac_pkg::BlockWidth-1:0]     key,
	input  logic [acmac_pkg::BlockWidth-1:0]     block_in,
	output logic [acmac_pkg::BlockWidth-1:0]     block_out,
	output logic                                 done
);
	logic [acmac_pkg::BlockWidth-1:0] state_q, rkey_q, rk_next;
	logic [3:0] round_q;
	logic [7:0] rcon_q;
	logic       busy_q;

	assign rk_next = acmac_pkg::next_round_key(rkey_q, rcon_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done    <= 1'b0;
			round_q <= '0;
			rcon_q  <= 8'h01;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				round_q <= 4'd1;
				rcon_q  <= 8'h01;
			end else if (busy_q) begin
				round_q <= round_q + 4'd1;
				rcon_q  <= acmac_pkg::xtime(rcon_q);
				if (round_q == 4'd10) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			state_q <= block_in ^ key;
			rkey_q  <= key;
		end else if (busy_q) begin
			state_q <= acmac_pkg::aes_round(state_q, rk_next, round_q == 4'd10);
			rkey_q  <= rk_next;
		end
	end

	assign block_out = state_q;
endmodule

[sv/acmac_datapath.sv]
// CMAC datapath: key, block buffer, subkeys, chain value, AES core and tag register.
module acmac_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [acmac_pkg::CfgIdxWidth-1:0] cfg_idx,
	input  logic [acmac_pkg::KeyWidth-1:0]    cfg_data,
	input  logic [7:0]                        byte_in,
	input  acmac_pkg::dp_cmd_t                cmd,
	output acmac_pkg::dp_status_t             status,
	output logic [acmac_pkg::BlockWidth-1:0]  tag
);
	localparam int unsigned BB = acmac_pkg::BlockBytes;

	logic [acmac_pkg::BlockWidth-1:0] key_q, k1_q, k2_q, chain_q, aes_in, aes_out;
	logic [acmac_pkg::BlockWidth-1:0] final_blk, tag_q;
	logic [7:0] buf_q [BB];
	logic [7:0] byte_hold_q;
	logic [acmac_pkg::FillWidth-1:0] fill_q;
	logic chained_q, aes_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q     <= '0;
			fill_q    <= '0;
			chained_q <= 1'b0;
			chain_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					acmac_pkg::RegKeyHigh: key_q[127:64] <= cfg_data;
					acmac_pkg::RegKeyLow:  key_q[63:0]   <= cfg_data;
					default: ;
				endcase
				fill_q    <= '0;
				chained_q <= 1'b0;
			end else if (cmd.msg_clear) begin
				fill_q    <= '0;
				chained_q <= 1'b0;
			end else begin
				if (cmd.keep_chain) begin
					chain_q   <= aes_out;
					chained_q <= 1'b1;
				end
				if (cmd.buf_write)
					fill_q <= (cmd.fill_clear ? '0 : fill_q) + 1'b1;
			end
		end
	end

	// hold the byte that waits for its full block to be chained; write the buffer, keep subkeys and tag
	always_ff @(posedge clk) begin
		if (cmd.aes_start && cmd.aes_src == acmac_pkg::SRC_CHAIN)
			byte_hold_q <= byte_in;
		if (cmd.buf_write)
			buf_q[cmd.fill_clear ? 4'd0 : fill_q[3:0]] <= cmd.fill_clear ? byte_hold_q : byte_in;
		if (cmd.keep_subkeys) begin
			k1_q <= acmac_pkg::dbl(aes_out);
			k2_q <= acmac_pkg::dbl(acmac_pkg::dbl(aes_out));
		end
		if (cmd.tag_load)
			tag_q <= aes_out;
	end

	always_comb begin
		logic [7:0] m;
		for (int i = 0; i < BB; i++) begin
			if (fill_q[4])
				m = buf_q[i];
			else if (i < fill_q)
				m = buf_q[i];
			else if (i == fill_q)
				m = acmac_pkg::CmacPad;
			else
				m = 8'h00;
			final_blk[acmac_pkg::BlockWidth-1-8*i -: 8] = m;
		end
		final_blk = final_blk ^ (fill_q[4] ? k1_q : k2_q);
	end

	always_comb begin
		logic [acmac_pkg::BlockWidth-1:0] b;
		for (int i = 0; i < BB; i++) b[acmac_pkg::BlockWidth-1-8*i -: 8] = buf_q[i];
		case (cmd.aes_src)
			acmac_pkg::SRC_ZERO:  aes_in = '0;
			acmac_pkg::SRC_CHAIN: aes_in = b ^ (chained_q ? chain_q : '0);
			acmac_pkg::SRC_FINAL: aes_in = final_blk ^ (chained_q ? chain_q : '0);
			default:              aes_in = '0;
		endcase
	end

	acmac_aes_core u_aes (
		.clk(clk), .arst_n(arst_n), .start(cmd.aes_start), .key(key_q),
		.block_in(aes_in), .block_out(aes_out), .done(aes_done)
	);

	assign status.aes_done = aes_done;
	assign status.buf_full = fill_q[4];
	assign tag = tag_q;
endmodule

[sv/acmac_ctrl.sv]
// CMAC controller: sequences subkey derivation, block chaining and tag output.
module acmac_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  has_byte,
	input  logic                  last_of_message,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  acmac_pkg::dp_status_t status,
	output acmac_pkg::dp_cmd_t    cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_SUBKEY, S_CHAIN, S_FSTART, S_FINAL, S_OUT
	} state_t;

	state_t state_q;
	logic   ready_q, last_q, acc;

	assign in_stall = (state_q != S_IDLE) || !ready_q;
	assign acc = in_valid && !in_stall;
	// ready_q here stands for subkeys valid; in_stall also covers derivation start
	always_comb begin
		cmd = '0;
		cmd.aes_src = acmac_pkg::SRC_ZERO;
		case (state_q)
			S_IDLE: begin
				if (!cfg_we && !ready_q) begin
					cmd.aes_start = 1'b1;
					cmd.aes_src   = acmac_pkg::SRC_ZERO;
				end else if (acc && has_byte) begin
					if (status.buf_full) begin
						cmd.aes_start = 1'b1;
						cmd.aes_src   = acmac_pkg::SRC_CHAIN;
					end else
						cmd.buf_write = 1'b1;
				end
			end
			S_SUBKEY: cmd.keep_subkeys = status.aes_done;
			S_CHAIN: begin
				if (status.aes_done) begin
					cmd.keep_chain = 1'b1;
					cmd.buf_write  = 1'b1;
					cmd.fill_clear = 1'b1;
				end
			end
			S_FSTART: begin
				cmd.aes_start = 1'b1;
				cmd.aes_src   = acmac_pkg::SRC_FINAL;
			end
			S_FINAL: begin
				cmd.aes_src = acmac_pkg::SRC_FINAL;
				if (status.aes_done) begin
					cmd.tag_load  = 1'b1;
					cmd.msg_clear = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ready_q   <= 1'b0;
			out_valid <= 1'b0;
			last_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cfg_we)
						ready_q <= 1'b0;
					else if (!ready_q)
						state_q <= S_SUBKEY;
					else if (acc) begin
						last_q <= last_of_message;
						if (has_byte && status.buf_full)
							state_q <= S_CHAIN;
						else if (last_of_message)
							state_q <= S_FSTART;
					end
				end
				S_SUBKEY: if (status.aes_done) begin
					ready_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_CHAIN: if (status.aes_done)
					state_q <= last_q ? S_FSTART : S_IDLE;
				S_FSTART: state_q <= S_FINAL;
				S_FINAL: if (status.aes_done) begin
					out_valid <= 1'b1;
					state_q   <= S_OUT;
				end
				S_OUT: if (!out_stall) begin
					out_valid <= 1'b0;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[sv/acmac_checker.sv]
// Port-level checker for the CMAC tag generator, bound to the top level.
module acmac_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] tag_high,
	input logic [63:0] tag_low
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tag_high) && $stable(tag_low))
		else $error("tag changed while stalled");

	a_no_take_with_tag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while tag pending");

	a_tag_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("tag without busy period");

	a_reset_stall: assert property (@(posedge clk)
		!arst_n |-> in_stall && !out_valid)
		else $error("block not stalled in reset");
endmodule

bind aes_cmac_tag_generator acmac_checker u_acmac_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .tag_high(tag_high), .tag_low(tag_low)
);

[verif/cmac_tag_checker.sv]
// Checker for the CMAC tag generator: watches the ports, predicts tags and compares.
`timescale 1ns / 1ps
module cmac_tag_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_idx,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        last_of_message,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [63:0] tag_high,
	input  logic [63:0] tag_low,
	output int          errors,
	output int          tags_pending
);
	logic [7:0]   sbox_lut [256];
	logic [127:0] cipher_key;
	logic [127:0] k1, k2, chain;
	logic [7:0]   msg_block [16];
	int unsigned  fill;
	logic         chained, keys_ok;
	logic [127:0] tag_queue [$];

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction

	function automatic logic [7:0] mul2(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	initial begin
		logic [7:0] inv, sq;
		for (int a = 0; a < 256; a++) begin
			inv = 8'h01;
			sq = a[7:0];
			for (int e = 0; e < 8; e++) begin
				if (e != 0) inv = gf_mul(inv, sq);
				sq = gf_mul(sq, sq);
			end
			if (a == 0) inv = 0;
			sbox_lut[a] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
				^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
		end
	end

	function automatic logic [127:0] encrypt(input logic [127:0] blk);
		logic [7:0] rk [16];
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] w0, w1, w2, w3, all, rc, tmp;
		logic [127:0] res;
		for (int i = 0; i < 16; i++) begin
			rk[i] = cipher_key[127-8*i -: 8];
			s[i] = blk[127-8*i -: 8] ^ rk[i];
		end
		rc = 8'h01;
		for (int r = 1; r <= 10; r++) begin
			tmp = rk[12];
			w0 = sbox_lut[rk[13]] ^ rc;
			w1 = sbox_lut[rk[14]];
			w2 = sbox_lut[rk[15]];
			w3 = sbox_lut[tmp];
			for (int c = 0; c < 4; c++) begin
				rk[4*c] ^= w0; rk[4*c+1] ^= w1; rk[4*c+2] ^= w2; rk[4*c+3] ^= w3;
				w0 = rk[4*c]; w1 = rk[4*c+1]; w2 = rk[4*c+2]; w3 = rk[4*c+3];
			end
			rc = mul2(rc);
			for (int c = 0; c < 4; c++)
				for (int i = 0; i < 4; i++)
					t[i+4*c] = sbox_lut[s[i+4*((c+i)&3)]];
			if (r < 10) begin
				for (int c = 0; c < 4; c++) begin
					w0 = t[4*c]; w1 = t[4*c+1]; w2 = t[4*c+2]; w3 = t[4*c+3];
					all = w0 ^ w1 ^ w2 ^ w3;
					t[4*c]   = w0 ^ all ^ mul2(w0 ^ w1);
					t[4*c+1] = w1 ^ all ^ mul2(w1 ^ w2);
					t[4*c+2] = w2 ^ all ^ mul2(w2 ^ w3);
					t[4*c+3] = w3 ^ all ^ mul2(w3 ^ w0);
				end
			end
			for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[i];
		end
		for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
		return res;
	endfunction

	function automatic logic [127:0] gf_double(input logic [127:0] v);
		return {v[126:0], 1'b0} ^ {120'd0, (v[127] ? acmac_pkg::CmacRb : 8'h00)};
	endfunction

	function automatic logic [127:0] block_word();
		logic [127:0] r;
		for (int i = 0; i < 16; i++) r[127-8*i -: 8] = msg_block[i];
		return r;
	endfunction

	task automatic absorb_beat(input logic [7:0] b, input logic hb, input logic lm);
		logic [127:0] fin;
		if (!keys_ok) begin
			k1 = gf_double(encrypt(128'd0));
			k2 = gf_double(k1);
			keys_ok = 1;
		end
		if (hb) begin
			if (fill >= 16) begin
				chain = encrypt(block_word() ^ (chained ? chain : 128'd0));
				chained = 1;
				fill = 0;
			end
			msg_block[fill] = b;
			fill++;
		end
		if (lm) begin
			if (fill >= 16) begin
				fin = block_word() ^ k1;
			end else begin
				for (int i = 0; i < 16; i++)
					fin[127-8*i -: 8] = (i < fill) ? msg_block[i] :
						(i == fill) ? acmac_pkg::CmacPad : 8'h00;
				fin ^= k2;
			end
			if (chained) fin ^= chain;
			tag_queue.push_back(encrypt(fin));
			fill = 0;
			chained = 0;
			chain = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [127:0] want;
		int bad;
		bad = 0;
		if (!arst_n) begin
			errors <= 0;
			cipher_key = 0;
			k1 = 0; k2 = 0; chain = 0;
			fill = 0; chained = 0; keys_ok = 0;
			tag_queue.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (tag_queue.size() == 0) begin
					$display("%0t: unexpected tag %h_%h", $time, tag_high, tag_low);
					bad++;
				end else begin
					want = tag_queue.pop_front();
					if (want[127:64] !== tag_high) begin
						$display("%0t: tag_high expected %h actual %h", $time, want[127:64], tag_high);
						bad++;
					end
					if (want[63:0] !== tag_low) begin
						$display("%0t: tag_low expected %h actual %h", $time, want[63:0], tag_low);
						bad++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_idx == acmac_pkg::RegKeyHigh) cipher_key[127:64] = cfg_data;
				else cipher_key[63:0] = cfg_data;
				keys_ok = 0;
				fill = 0; chained = 0; chain = 0;
			end
			if (in_valid && !in_stall) absorb_beat(data_byte, has_byte, last_of_message);
			errors <= errors + bad;
		end
		tags_pending = tag_queue.size();
	end
endmodule

[verif/tb_aes_cmac_tag_generator.sv]
// Testbench top for the CMAC tag generator: stimulus, stall patterns and verdict.
`timescale 1ns / 1ps
module tb_aes_cmac_tag_generator;
	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [0:0]  cfg_idx = acmac_pkg::RegKeyHigh;
	logic [63:0] cfg_data = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [7:0]  data_byte = 0;
	logic        has_byte = 0;
	logic        last_of_message = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [63:0] tag_high, tag_low;
	int          errors, tags_pending;
	int          idle_pct = 0, stall_pct = 0;
	int          beats_sent = 0, quiet = 0;

	localparam int QuietLimit = 3000;

	always #5 clk = ~clk;

	aes_cmac_tag_generator DUT (.*);

	cmac_tag_checker u_checker (.*);

	always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !arst_n) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= QuietLimit) begin
			$display("FAIL aes_cmac_tag_generator");
			$finish;
		end
	end

	task automatic send_beat(input logic [7:0] b, input logic hb, input logic lm);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 0;
			@(negedge clk);
		end
		in_valid = 1;
		data_byte = b;
		has_byte = hb;
		last_of_message = lm;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		beats_sent++;
	endtask

	task automatic drain();
		in_valid = 0;
		while (tags_pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic load_key(input logic [127:0] k);
		drain();
		cfg_we = 1;
		cfg_idx = acmac_pkg::RegKeyHigh;
		cfg_data = k[127:64];
		@(negedge clk);
		cfg_idx = acmac_pkg::RegKeyLow;
		cfg_data = k[63:0];
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic send_message(input int len, input logic split_end);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(9) == 0) send_beat(8'($urandom), 0, 0);
			send_beat(8'($urandom), 1, (i == len - 1) && !split_end);
		end
		if (split_end || len == 0) send_beat(8'($urandom), 0, 1);
	endtask

	initial begin
		logic [127:0] k;
		int len;
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send_beat(8'h00, 0, 1);
		send_beat(8'h00, 1, 1);
		send_beat(8'hff, 1, 1);
		send_beat(8'h5a, 0, 0);
		for (int i = 0; i < 16; i++) send_beat(i[0] ? 8'hff : 8'h00, 1, i == 15);
		load_key(128'h2b7e151628aed2a6abf7158809cf4f3c);
		send_beat(8'h00, 0, 1);
		for (int i = 0; i < 16; i++) send_beat(8'h80 | i[7:0], 1, 0);
		send_beat(8'h00, 0, 1);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  k = '1; end
				1: begin idle_pct = 48; stall_pct = 0;  k = '0; end
				2: begin idle_pct = 0;  stall_pct = 48; k = {$urandom, $urandom, $urandom, $urandom}; end
				default: begin idle_pct = 28; stall_pct = 28; k = {$urandom, $urandom, $urandom, $urandom}; end
			endcase
			load_key(k);
			while (beats_sent < 40 + 270 * (ph + 1)) begin
				if ($urandom_range(7) == 0) len = $urandom_range(33, 48);
				else len = $urandom_range(0, 20);
				if ($urandom_range(9) == 0) send_message($urandom_range(1, 20), 1'b0);
				send_message(len, $urandom_range(2) == 0);
				if (ph == 1 && $urandom_range(3) == 0) begin
					in_valid = 0;
					repeat ($urandom_range(1, 30)) @(negedge clk);
				end
			end
			for (int i = 0; i < $urandom_range(1, 20); i++) send_beat(8'($urandom), 1, 0);
		end

		idle_pct = 0;
		stall_pct = 0;
		drain();
		if (errors == 0) $display("PASS aes_cmac_tag_generator");
		else $display("FAIL aes_cmac_tag_generator");
		$finish;
	end
endmodule

[aes_cmac_tag_generator.f]
sv/acmac_pkg.sv
sv/acmac_aes_core.sv
sv/acmac_datapath.sv
sv/acmac_ctrl.sv
sv/aes_cmac_tag_generator.sv
sv/acmac_checker.sv
verif/cmac_tag_checker.sv
verif/tb_aes_cmac_tag_generator.sv
